@@ src/a64su_pkg.sv @@
// ----------------------------------------------------------------------------
// a64su_pkg
// Shared types, constants and the instruction decoder of the A64 subset unit.
// ----------------------------------------------------------------------------
package a64su_pkg;

	localparam int unsigned MemWordsDefault = 4096;

	localparam logic [31:0] MaskTop11 = 32'hFFE0_0000;
	localparam logic [31:0] MaskTop10 = 32'hFFC0_0000;
	localparam logic [31:0] MaskTop8  = 32'hFF00_0000;
	localparam logic [31:0] MaskTop6  = 32'hFC00_0000;
	localparam logic [31:0] MaskBr    = 32'hFFFF_FC1F;

	localparam logic [31:0] EncHlt   = 32'hD440_0000;
	localparam logic [31:0] EncAdd   = 32'h8B20_0000;
	localparam logic [31:0] EncAdds  = 32'hAB00_0000;
	localparam logic [31:0] EncSubs  = 32'hEB00_0000;
	localparam logic [31:0] EncAnds  = 32'hEA00_0000;
	localparam logic [31:0] EncMul   = 32'h9B00_0000;
	localparam logic [31:0] EncOrr   = 32'hAA00_0000;
	localparam logic [31:0] EncEor   = 32'hCA00_0000;
	localparam logic [31:0] EncMovz  = 32'hD280_0000;
	localparam logic [31:0] EncStur  = 32'hF800_0000;
	localparam logic [31:0] EncLdur  = 32'hF840_0000;
	localparam logic [31:0] EncSturb = 32'h3800_0000;
	localparam logic [31:0] EncSturh = 32'h7800_0000;
	localparam logic [31:0] EncLdurb = 32'h3840_0000;
	localparam logic [31:0] EncLdurh = 32'h7840_0000;
	localparam logic [31:0] EncUbfm  = 32'hD340_0000;
	localparam logic [31:0] EncSubsi = 32'hF100_0000;
	localparam logic [31:0] EncCbz   = 32'hB400_0000;
	localparam logic [31:0] EncCbnz  = 32'hB500_0000;
	localparam logic [31:0] EncBcond = 32'h5400_0000;
	localparam logic [31:0] EncAddsi = 32'hB100_0000;
	localparam logic [31:0] EncAddi  = 32'h9100_0000;
	localparam logic [31:0] EncB     = 32'h1400_0000;
	localparam logic [31:0] EncBr    = 32'hD61F_0000;

	localparam logic [3:0] CondEq = 4'h0;
	localparam logic [3:0] CondNe = 4'h1;
	localparam logic [3:0] CondGe = 4'hA;
	localparam logic [3:0] CondLt = 4'hB;
	localparam logic [3:0] CondGt = 4'hC;
	localparam logic [3:0] CondLe = 4'hD;

	localparam logic [4:0] RegZr = 5'd31;

	typedef enum logic [4:0] {
		OP_HLT, OP_ADD, OP_ADDS, OP_SUBS, OP_ANDS, OP_MUL, OP_ORR, OP_EOR,
		OP_MOVZ, OP_ST64, OP_LD64, OP_STN, OP_LDN, OP_UBFM, OP_SUBSI,
		OP_CB, OP_BCOND, OP_ADDI, OP_B, OP_BR, OP_ILL
	} op_t;

	typedef struct packed {
		logic        wr;
		logic [63:0] wval;
		logic        setnz;
		logic [63:0] npc;
		logic        illegal;
		logic        halt;
	} alu_res_t;

	function automatic op_t decode(input logic [31:0] ins);
		logic [31:0] t11;
		logic [31:0] t10;
		logic [31:0] t8;
		op_t         op;
		t11 = ins & MaskTop11;
		t10 = ins & MaskTop10;
		t8  = ins & MaskTop8;
		if (t11 == EncHlt) op = OP_HLT;
		else if (t11 == EncAdd) op = OP_ADD;
		else if (t11 == EncAdds) op = OP_ADDS;
		else if (t11 == EncSubs) op = OP_SUBS;
		else if (t11 == EncAnds) op = OP_ANDS;
		else if (t11 == EncMul) op = OP_MUL;
		else if (t11 == EncOrr) op = OP_ORR;
		else if (t11 == EncEor) op = OP_EOR;
		else if (t11 == EncMovz) op = OP_MOVZ;
		else if (t11 == EncStur) op = OP_ST64;
		else if (t11 == EncLdur) op = OP_LD64;
		else if (t11 == EncSturb || t11 == EncSturh) op = OP_STN;
		else if (t11 == EncLdurb || t11 == EncLdurh) op = OP_LDN;
		else if (t10 == EncUbfm) op = OP_UBFM;
		else if (t10 == EncSubsi) op = OP_SUBSI;
		else if (t8 == EncCbz || t8 == EncCbnz) op = OP_CB;
		else if (t8 == EncBcond) op = OP_BCOND;
		else if (t8 == EncAddsi || t8 == EncAddi) op = OP_ADDI;
		else if ((ins & MaskTop6) == EncB) op = OP_B;
		else if ((ins & MaskBr) == EncBr) op = OP_BR;
		else op = OP_ILL;
		return op;
	endfunction

	// Second register read port takes Rd for stores and compare-branches.
	function automatic logic uses_rd(input op_t op);
		return (op == OP_ST64) || (op == OP_STN) || (op == OP_CB);
	endfunction

endpackage

@@ src/a64su_if.sv @@
// ----------------------------------------------------------------------------
// a64su channel interfaces
// Valid/ready channels for instruction items and execution results.
// ----------------------------------------------------------------------------
interface a64su_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] instruction;
	logic [11:0] load_address;
	logic [31:0] load_data;

	modport source (output valid, action, instruction, load_address, load_data,
		input ready);
	modport sink (input valid, action, instruction, load_address, load_data,
		output ready);
endinterface

interface a64su_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] next_pc;
	logic        halted;
	logic        illegal;
	logic        flag_n_out;
	logic        flag_z_out;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [63:0] reg_value;

	modport source (output valid, next_pc, halted, illegal, flag_n_out, flag_z_out,
		reg_written, reg_index, reg_value, input ready);
	modport sink (input valid, next_pc, halted, illegal, flag_n_out, flag_z_out,
		reg_written, reg_index, reg_value, output ready);
endinterface

@@ src/a64su_ram.sv @@
// ----------------------------------------------------------------------------
// a64su_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module a64su_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/a64su_alu.sv @@
// ----------------------------------------------------------------------------
// a64su_alu
// Combinational execution of register, immediate and branch instructions.
// ----------------------------------------------------------------------------
module a64su_alu (
	input  a64su_pkg::op_t     op,
	input  logic [31:0]        ins,
	input  logic [63:0]        xn,
	input  logic [63:0]        x2,
	input  logic [63:0]        pc,
	input  logic               fn,
	input  logic               fz,
	output a64su_pkg::alu_res_t res
);
	logic [63:0] pc4;
	logic [63:0] br19;
	logic [63:0] br26;
	logic [63:0] imm12;
	logic [5:0]  immr;
	logic        take;

	assign pc4  = pc + 64'd4;
	assign br19 = {{43{ins[23]}}, ins[23:5], 2'b00};
	assign br26 = {{36{ins[25]}}, ins[25:0], 2'b00};
	assign immr = ins[21:16];
	assign imm12 = (ins[23:22] == 2'b01) ? {40'd0, ins[21:10], 12'd0}
		: {52'd0, ins[21:10]};

	always_comb begin
		case (ins[3:0])
			a64su_pkg::CondEq: take = fz;
			a64su_pkg::CondNe: take = !fz;
			a64su_pkg::CondGe: take = !fn;
			a64su_pkg::CondLt: take = fn;
			a64su_pkg::CondGt: take = !fz && !fn;
			a64su_pkg::CondLe: take = fz || fn;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		res = '0;
		res.npc = pc4;
		case (op)
			a64su_pkg::OP_HLT: res.halt = 1'b1;
			a64su_pkg::OP_ADD: begin
				res.wr = 1'b1;
				res.wval = xn + x2;
			end
			a64su_pkg::OP_ADDS: begin
				res.wr = 1'b1;
				res.wval = xn + x2;
				res.setnz = 1'b1;
			end
			a64su_pkg::OP_SUBS: begin
				res.wr = (ins[4:0] != a64su_pkg::RegZr);
				res.wval = xn - x2;
				res.setnz = 1'b1;
			end
			a64su_pkg::OP_ANDS: begin
				res.wr = 1'b1;
				res.wval = xn & x2;
				res.setnz = 1'b1;
			end
			a64su_pkg::OP_ORR: begin
				res.wr = 1'b1;
				res.wval = xn | (x2 << ins[15:10]);
			end
			a64su_pkg::OP_EOR: begin
				res.wr = 1'b1;
				res.wval = xn ^ x2;
			end
			a64su_pkg::OP_MOVZ: begin
				res.wr = 1'b1;
				res.wval = {48'd0, ins[20:5]};
			end
			a64su_pkg::OP_UBFM: begin
				res.wr = 1'b1;
				res.wval = (ins[15:10] == 6'h3F) ? (xn >> immr) : (xn << (6'd0 - immr));
			end
			a64su_pkg::OP_SUBSI: begin
				res.wr = (ins[4:0] != a64su_pkg::RegZr);
				res.wval = xn - {52'd0, ins[21:10]};
				res.setnz = 1'b1;
			end
			a64su_pkg::OP_CB: begin
				// CBZ when bit 24 is clear, CBNZ when set
				if ((x2 == 64'd0) ^ ins[24]) begin
					res.npc = pc + br19;
				end
			end
			a64su_pkg::OP_BCOND: begin
				if (take) begin
					res.npc = pc + br19;
				end
			end
			a64su_pkg::OP_ADDI: begin
				res.wr = 1'b1;
				res.wval = xn + imm12;
				res.setnz = ins[29];
			end
			a64su_pkg::OP_B: res.npc = pc + br26;
			a64su_pkg::OP_BR: res.npc = xn;
			a64su_pkg::OP_ILL: res.illegal = 1'b1;
			default: res.npc = pc4;
		endcase
	end
endmodule

@@ src/arm64_subset_execute_unit.sv @@
// ----------------------------------------------------------------------------
// arm64_subset_execute_unit
// Executes one A64 instruction or one data memory preload per input transfer.
// ----------------------------------------------------------------------------
// Input channel in_ch carries action, instruction and preload fields; output
// channel out_ch carries one result per input transfer, in order.
// Registers and data memory live in synchronous RAMs (registered read data). The
// register file is two RAM copies so Rn and Rm (or Rd) read in the same cycle.
// States per item, from input transfer to result in the output buffer:
//   EXEC for preloads and register, immediate and branch instructions,
//   EXEC, MEM1 for byte/halfword loads and stores and 64-bit stores,
//   EXEC, MEM1, MEM2 for 64-bit loads and EXEC, MUL1, MUL2 for MUL (two data
//   memory reads, three products from the shared 32x32 multiplier).
// A new input transfer is taken only in ST_IDLE, after the previous result lands.
// Results queue in a two-entry output buffer. A stalled receiver holds them;
// the next item is accepted only while the second entry is free or the
// receiver drains in that cycle.
// cfg_we loads the PC. Reset clears registers (through valid bits), flags and
// PC, sets the run bit; data memory is undefined until written.
// MEM_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module arm64_subset_execute_unit #(
	parameter int unsigned MEM_WORDS = a64su_pkg::MemWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	a64su_in_if.sink    in_ch,
	a64su_out_if.source out_ch
);
	localparam int unsigned AW = $clog2(MEM_WORDS);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MEM1, ST_MEM2, ST_MUL1, ST_MUL2
	} state_t;

	typedef struct packed {
		logic [63:0] pc;
		logic        halt;
		logic        ill;
		logic        n;
		logic        z;
		logic        wr;
		logic [4:0]  idx;
		logic [63:0] val;
	} out_res_t;

	state_t             st_q, st_d;
	a64su_pkg::op_t     op_q, in_op;
	logic [31:0]        ins_q;
	logic               act_q;
	logic [AW-1:0]      laddr_q;
	logic [31:0]        ldata_q;
	logic [4:0]         rn_q, r2_q;
	logic [63:0]        pc_q, pc_d;
	logic               fn_q, fz_q, run_q;
	logic               fn_d, fz_d, run_d;
	logic [31:0]        vld_q;
	logic [AW-1:0]      mw_q;
	logic [1:0]         lane_q;
	logic               sz16_q;
	logic [31:0]        lo_q;
	logic [63:0]        acc_q;
	logic [63:0]        opa_q, opb_q;

	logic               accept, fin;
	logic [4:0]         in_r2;
	logic [63:0]        rfa_rd, rfb_rd, xn, x2;
	logic               rf_we;
	logic [4:0]         rf_wi;
	logic [63:0]        rf_wv;
	logic               dm_we;
	logic [AW-1:0]      dm_wa, dm_ra;
	logic [31:0]        dm_wd, dm_rd;
	logic [63:0]        addr;
	logic [AW-1:0]      w0;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod;
	logic [31:0]        lmask;
	logic [4:0]         lsh;
	logic               o_ill, o_wr;
	logic [63:0]        o_val;
	a64su_pkg::alu_res_t alu;

	logic        ov_q, hv_q, head_free;
	out_res_t    fin_res, o_q, h_q;

	assign in_op  = a64su_pkg::decode(in_ch.instruction);
	assign in_r2  = a64su_pkg::uses_rd(in_op) ? in_ch.instruction[4:0]
		: in_ch.instruction[20:16];
	assign head_free   = !ov_q || out_ch.ready;
	assign in_ch.ready = (st_q == ST_IDLE) && (!hv_q || out_ch.ready);
	assign accept = in_ch.valid && in_ch.ready;

	a64su_ram #(.WIDTH(64), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_wi), .wdata(rf_wv),
		.raddr(in_ch.instruction[9:5]), .rdata(rfa_rd)
	);
	a64su_ram #(.WIDTH(64), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_wi), .wdata(rf_wv),
		.raddr(in_r2), .rdata(rfb_rd)
	);
	a64su_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
		.raddr(dm_ra), .rdata(dm_rd)
	);

	// Entries never written since reset read as zero.
	assign xn = vld_q[rn_q] ? rfa_rd : 64'd0;
	assign x2 = vld_q[r2_q] ? rfb_rd : 64'd0;

	assign addr = xn + {{55{ins_q[20]}}, ins_q[20:12]};
	assign w0   = addr[AW+1:2];

	a64su_alu u_alu (
		.op(op_q), .ins(ins_q), .xn(xn), .x2(x2), .pc(pc_q),
		.fn(fn_q), .fz(fz_q), .res(alu)
	);

	always_comb begin
		case (st_q)
			ST_MUL1: begin
				mul_a = opa_q[31:0];
				mul_b = opb_q[63:32];
			end
			ST_MUL2: begin
				mul_a = opa_q[63:32];
				mul_b = opb_q[31:0];
			end
			default: begin
				mul_a = xn[31:0];
				mul_b = x2[31:0];
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign lsh   = {lane_q, 3'b000};
	assign lmask = (sz16_q ? 32'h0000_FFFF : 32'h0000_00FF) << lsh;

	always_comb begin
		st_d  = st_q;
		pc_d  = pc_q;
		fn_d  = fn_q;
		fz_d  = fz_q;
		run_d = run_q;
		fin   = 1'b0;
		o_ill = 1'b0;
		o_wr  = 1'b0;
		o_val = 64'd0;
		dm_we = 1'b0;
		dm_wa = mw_q;
		dm_wd = 32'd0;
		dm_ra = w0;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					st_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (act_q) begin
					dm_we = 1'b1;
					dm_wa = laddr_q;
					dm_wd = ldata_q;
					fin   = 1'b1;
				end else if (!run_q) begin
					fin = 1'b1;
				end else begin
					case (op_q)
						a64su_pkg::OP_LD64, a64su_pkg::OP_LDN, a64su_pkg::OP_STN: begin
							pc_d = pc_q + 64'd4;
							st_d = ST_MEM1;
						end
						a64su_pkg::OP_ST64: begin
							dm_we = 1'b1;
							dm_wa = w0;
							dm_wd = x2[31:0];
							pc_d  = pc_q + 64'd4;
							st_d  = ST_MEM1;
						end
						a64su_pkg::OP_MUL: begin
							pc_d = pc_q + 64'd4;
							st_d = ST_MUL1;
						end
						default: begin
							fin   = 1'b1;
							pc_d  = alu.npc;
							run_d = !alu.halt;
							o_ill = alu.illegal;
							o_wr  = alu.wr;
							o_val = alu.wval;
							if (alu.setnz) begin
								fn_d = alu.wval[63];
								fz_d = (alu.wval == 64'd0);
							end
						end
					endcase
				end
			end
			ST_MEM1: begin
				case (op_q)
					a64su_pkg::OP_LD64: begin
						dm_ra = mw_q;
						st_d  = ST_MEM2;
					end
					a64su_pkg::OP_ST64: begin
						dm_we = 1'b1;
						dm_wd = opb_q[63:32];
						fin   = 1'b1;
					end
					a64su_pkg::OP_LDN: begin
						fin   = 1'b1;
						o_wr  = 1'b1;
						o_val = {32'd0, (dm_rd & lmask) >> lsh};
					end
					default: begin
						// merge the byte or halfword lane into the old word
						dm_we = 1'b1;
						dm_wd = (dm_rd & ~lmask) | ((opb_q[31:0] << lsh) & lmask);
						fin   = 1'b1;
					end
				endcase
			end
			ST_MEM2: begin
				fin   = 1'b1;
				o_wr  = 1'b1;
				o_val = {dm_rd, lo_q};
			end
			ST_MUL1: st_d = ST_MUL2;
			ST_MUL2: begin
				fin   = 1'b1;
				o_wr  = 1'b1;
				o_val = acc_q + {prod[31:0], 32'd0};
			end
			default: st_d = ST_IDLE;
		endcase
		if (fin) begin
			st_d = ST_IDLE;
		end
	end

	assign rf_we = fin && o_wr;
	assign rf_wi = ins_q[4:0];
	assign rf_wv = o_val;

	assign fin_res = {pc_d, !run_d, o_ill, fn_d, fz_d, o_wr,
		o_wr ? ins_q[4:0] : 5'd0, o_wr ? o_val : 64'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			pc_q  <= 64'd0;
			fn_q  <= 1'b0;
			fz_q  <= 1'b0;
			run_q <= 1'b1;
			vld_q <= '0;
			ov_q  <= 1'b0;
			hv_q  <= 1'b0;
		end else begin
			st_q  <= st_d;
			pc_q  <= cfg_we ? cfg_wdata : pc_d;
			fn_q  <= fn_d;
			fz_q  <= fz_d;
			run_q <= run_d;
			if (rf_we) begin
				vld_q[rf_wi] <= 1'b1;
			end
			// refill the head from the second entry, else from the finishing item
			if (head_free) begin
				ov_q <= hv_q || fin;
				hv_q <= hv_q && fin;
			end else if (fin) begin
				hv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q   <= in_ch.instruction;
			op_q    <= in_op;
			act_q   <= in_ch.action;
			laddr_q <= AW'(in_ch.load_address);
			ldata_q <= in_ch.load_data;
			rn_q    <= in_ch.instruction[9:5];
			r2_q    <= in_r2;
		end
		if (st_q == ST_EXEC) begin
			opa_q  <= xn;
			opb_q  <= x2;
			acc_q  <= prod;
			lane_q <= addr[1:0];
			sz16_q <= ins_q[30];
			mw_q   <= (op_q == a64su_pkg::OP_STN || op_q == a64su_pkg::OP_LDN)
				? w0 : w0 + AW'(1);
		end
		if (st_q == ST_MEM1) begin
			lo_q <= dm_rd;
		end
		if (st_q == ST_MUL1) begin
			acc_q <= acc_q + {prod[31:0], 32'd0};
		end
		if (head_free) begin
			if (hv_q) begin
				o_q <= h_q;
			end else if (fin) begin
				o_q <= fin_res;
			end
		end
		if (fin && (hv_q || !head_free)) begin
			h_q <= fin_res;
		end
	end

	assign out_ch.valid       = ov_q;
	assign out_ch.next_pc     = o_q.pc;
	assign out_ch.halted      = o_q.halt;
	assign out_ch.illegal     = o_q.ill;
	assign out_ch.flag_n_out  = o_q.n;
	assign out_ch.flag_z_out  = o_q.z;
	assign out_ch.reg_written = o_q.wr;
	assign out_ch.reg_index   = o_q.idx;
	assign out_ch.reg_value   = o_q.val;

	// a finishing item always finds a free buffer entry
	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !hv_q)
		else $error("result arrived with the output buffer full");

	// no register write may race a read issued by a new transfer
	a_rf_race: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> !accept)
		else $error("register write coincides with input transfer");

	// once halted, only a configuration write moves the PC
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(!run_q && !cfg_we) |=> $stable(pc_q))
		else $error("PC changed while halted");

	// a result never finishes in the cycle of its own transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !fin)
		else $error("result produced without execution cycle");
endmodule
